@@ design/ssh_pkg.sv @@
package ssh_pkg;

	localparam int SS_BITS  = 8;
	localparam int SUB_BITS = 4;
	localparam int HIT_W    = SS_BITS + SUB_BITS;
	localparam int LAYER_W  = 3;
	localparam int CODE_W   = 8;
	localparam int CFG_IDX_W = 1;

	localparam int DEF_LAYERS   = 8;
	localparam int DEF_MAX_HITS = 16;

	localparam logic [CODE_W-1:0] IDLE_CODE_RESET  = 8'd255;
	localparam logic [CODE_W-1:0] START_CODE_RESET = 8'd254;

	localparam logic [CFG_IDX_W-1:0] CFG_IDLE_CODE  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_CODE = 1'd1;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_WRITE  = 2'd1,
		CMD_SEARCH = 2'd2
	} cmd_t;

	typedef struct packed {
		cmd_t                command;
		logic [LAYER_W-1:0]  layer;
		logic [SS_BITS-1:0]  superstrip;
		logic [SUB_BITS-1:0] substrip;
	} req_t;

	typedef struct packed {
		logic [LAYER_W-1:0] out_layer;
		logic [HIT_W-1:0]   hit;
		logic               last;
		logic               dropped;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_STREAM,
		ST_DROP
	} state_t;

endpackage

@@ design/superstrip_hit_memory.sv @@
// Per-layer hit store keyed by superstrip, driven by one small sequencer around three
// memories: a valid row per superstrip (one bit per layer), a read flag and hit count per
// entry, and the substrip lists. After reset, and after every new-event command, the valid
// rows are swept to zero one superstrip per cycle with req_ready low; configuration writes
// are taken meanwhile. A write beat is accepted, then looked up and updated; when the list is
// full, a dropped beat is produced instead. A search is accepted and looked up, then streams
// any stored hits; hits come out of the substrip memory at one per cycle while rsp_ready
// stays high, the last one flagged. Searches on missing, already read or sentinel
// superstrips, and accesses to layers beyond LAYERS, produce no result.
module superstrip_hit_memory #(
	parameter int LAYERS   = ssh_pkg::DEF_LAYERS,
	parameter int MAX_HITS = ssh_pkg::DEF_MAX_HITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  ssh_pkg::req_t                 req,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output ssh_pkg::rsp_t                 rsp,
	input  logic                          cfg_we,
	input  logic [ssh_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ssh_pkg::CODE_W-1:0]    cfg_data
);
	import ssh_pkg::*;

	localparam int LAY_W    = (LAYERS > 1) ? $clog2(LAYERS) : 1;
	localparam int PTR_W    = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
	localparam int CNT_W    = $clog2(MAX_HITS + 1);
	localparam int IDX_W    = LAY_W + SS_BITS;
	localparam int SS_COUNT = 1 << SS_BITS;
	localparam int ENTRIES  = 1 << IDX_W;
	localparam int STORE_D  = 1 << (IDX_W + PTR_W);

	typedef struct packed {
		logic             rd;
		logic [CNT_W-1:0] cnt;
	} meta_t;

	logic [LAYERS-1:0]   vld_mem [SS_COUNT];
	meta_t               meta_mem [ENTRIES];
	logic [SUB_BITS-1:0] store_mem [STORE_D];

	state_t              state_q, state_d;
	req_t                item_q;
	logic [SS_BITS-1:0]  clr_ptr_q;
	logic [PTR_W-1:0]    ptr_q;
	logic [CNT_W-1:0]    cnt_q;
	rsp_t                rsp_q;
	logic                rsp_valid_q;
	logic [CODE_W-1:0]   idle_q, start_q;

	logic [LAYERS-1:0]   vld_row_q;
	meta_t               meta_q;
	logic [SUB_BITS-1:0] store_q;

	logic                vld_we;
	logic [SS_BITS-1:0]  vld_waddr, vld_raddr;
	logic [LAYERS-1:0]   vld_wdata;
	logic                meta_we;
	meta_t               meta_wdata;
	logic                store_we;
	logic [PTR_W-1:0]    store_wptr, store_rptr;

	logic [LAY_W-1:0]    lay_idx;
	logic [IDX_W-1:0]    idx;
	logic                entry_valid;
	logic [CNT_W-1:0]    cur_cnt;
	logic                usable;
	logic                out_free;
	logic                out_load;
	rsp_t                out_data;
	logic                ptr_clr, ptr_inc, cnt_load;
	logic                accept;

	assign lay_idx     = LAY_W'(item_q.layer);
	assign idx         = {lay_idx, item_q.superstrip};
	assign entry_valid = vld_row_q[lay_idx];
	assign cur_cnt     = entry_valid ? meta_q.cnt : '0;
	assign usable      = (32'(item_q.layer) < LAYERS) && (item_q.superstrip != idle_q)
		&& (item_q.superstrip != start_q);
	assign out_free    = !rsp_valid_q || rsp_ready;
	assign accept      = req_valid && req_ready;
	assign vld_raddr   = (state_q == ST_IDLE) ? req.superstrip : item_q.superstrip;

	always_ff @(posedge clk) begin
		if (vld_we)
			vld_mem[vld_waddr] <= vld_wdata;
		vld_row_q <= vld_mem[vld_raddr];
	end

	always_ff @(posedge clk) begin
		if (meta_we)
			meta_mem[idx] <= meta_wdata;
		meta_q <= meta_mem[{LAY_W'(req.layer), req.superstrip}];
	end

	always_ff @(posedge clk) begin
		if (store_we)
			store_mem[{idx, store_wptr}] <= item_q.substrip;
		store_q <= store_mem[{idx, store_rptr}];
	end

	always_comb begin
		state_d    = state_q;
		req_ready  = 1'b0;
		vld_we     = 1'b0;
		vld_waddr  = item_q.superstrip;
		vld_wdata  = vld_row_q;
		meta_we    = 1'b0;
		meta_wdata = meta_q;
		store_we   = 1'b0;
		store_wptr = cur_cnt[PTR_W-1:0];
		store_rptr = ptr_q;
		out_load   = 1'b0;
		out_data   = '0;
		ptr_clr    = 1'b0;
		ptr_inc    = 1'b0;
		cnt_load   = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				vld_we    = 1'b1;
				vld_waddr = clr_ptr_q;
				vld_wdata = '0;
				if (clr_ptr_q == SS_BITS'(SS_COUNT - 1))
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					if (req.command == CMD_CLEAR)
						state_d = ST_CLEAR;
					else
						state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				state_d    = ST_IDLE;
				ptr_clr    = 1'b1;
				cnt_load   = 1'b1;
				store_rptr = '0;
				if (usable) begin
					case (item_q.command)
						CMD_WRITE: begin
							if (32'(cur_cnt) >= MAX_HITS) begin
								state_d = ST_DROP;
							end else begin
								store_we           = 1'b1;
								meta_we            = 1'b1;
								meta_wdata.rd      = 1'b0;
								meta_wdata.cnt     = cur_cnt + 1'b1;
								vld_we             = 1'b1;
								vld_wdata[lay_idx] = 1'b1;
							end
						end
						CMD_SEARCH: begin
							if (entry_valid && !meta_q.rd) begin
								// Marked read now; the list itself is left untouched.
								meta_we       = 1'b1;
								meta_wdata.rd = 1'b1;
								if (cur_cnt != '0)
									state_d = ST_STREAM;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_STREAM: begin
				out_data.out_layer = item_q.layer;
				out_data.hit       = {item_q.superstrip, store_q};
				out_data.last      = (CNT_W'(ptr_q) + 1'b1) == cnt_q;
				out_data.dropped   = 1'b0;
				if (out_free) begin
					out_load   = 1'b1;
					ptr_inc    = 1'b1;
					// Fetch the next substrip so that it is ready by the next cycle.
					store_rptr = ptr_q + 1'b1;
					if (out_data.last)
						state_d = ST_IDLE;
				end
			end
			ST_DROP: begin
				out_data.out_layer = item_q.layer;
				out_data.hit       = {item_q.superstrip, item_q.substrip};
				out_data.last      = 1'b0;
				out_data.dropped   = 1'b1;
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_ptr_q   <= '0;
			rsp_valid_q <= 1'b0;
			idle_q      <= IDLE_CODE_RESET;
			start_q     <= START_CODE_RESET;
		end else begin
			if (state_q == ST_CLEAR)
				clr_ptr_q <= clr_ptr_q + 1'b1;
			else
				clr_ptr_q <= '0;
			if (out_load)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					CFG_IDLE_CODE:  idle_q  <= cfg_data;
					CFG_START_CODE: start_q <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			item_q <= req;
		if (ptr_clr)
			ptr_q <= '0;
		else if (ptr_inc)
			ptr_q <= ptr_q + 1'b1;
		if (cnt_load)
			cnt_q <= cur_cnt;
		if (out_load)
			rsp_q <= out_data;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
